/* hw/rtl/sng_pkg.sv */
// ----------------------------------------------------------------------------
// sng_pkg
// Shared types, register codes and the volume table of the square and noise
// sound generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sng_pkg;

    localparam int TONE_CHANNELS = 3;
    localparam int CH_W          = (TONE_CHANNELS > 1) ? $clog2(TONE_CHANNELS) : 1;

    localparam int MAX_SAMPLES   = 64;
    localparam int SCNT_W        = $clog2(MAX_SAMPLES + 1);

    // tone divider works on count[16:4] against the 12-bit period
    localparam int DIV_STEPS     = 13;
    localparam int DCNT_W        = $clog2(DIV_STEPS);

    localparam int SUM_W         = 19;
    localparam int MAX_AMPL      = 32'h7FFF;

    localparam logic [12:0] CPS_RESET = 13'd81;
    localparam logic [12:0] CPS_MIN   = 13'd16;
    localparam logic [12:0] CPS_MAX   = 13'd4096;
    localparam logic [13:0] PHASE_SAT = 14'h1FFF;
    localparam logic [15:0] LFSR_SEED = 16'h8000;
    localparam logic [12:0] NOISE_BASE = 13'd256;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // latched register numbers
    localparam logic [2:0] REG_TONE0_LO  = 3'd0;
    localparam logic [2:0] REG_TONE0_HI  = 3'd1;
    localparam logic [2:0] REG_TONE1_LO  = 3'd2;
    localparam logic [2:0] REG_TONE1_HI  = 3'd3;
    localparam logic [2:0] REG_TONE2_LO  = 3'd4;
    localparam logic [2:0] REG_TONE2_HI  = 3'd5;
    localparam logic [2:0] REG_NOISE     = 3'd6;
    localparam logic [2:0] REG_ENABLE    = 3'd7;
    localparam logic [2:0] REG_NOISE_VOL = 3'd3;

    localparam logic [13:0] VOL_LOG [16] = '{
        14'h0000, 14'h0055, 14'h0079, 14'h00AB, 14'h00F1, 14'h0155, 14'h01E3, 14'h02AA,
        14'h03C5, 14'h0555, 14'h079A, 14'h0AAB, 14'h0F16, 14'h1555, 14'h1E2B, 14'h2AAA
    };

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic [9:0] cycle_count;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            bus_write;
        logic            advance;
        logic            take_sample;
        logic            finish;
        logic            tone_load;
        logic            div_step;
        logic            tone_store;
        logic            noise_add;
        logic            noise_step;
        logic            noise_store;
        logic            mix_load;
    } sng_cmd_t;

    typedef struct packed {
        logic sample_due;
        logic tone_active;
        logic noise_enabled;
        logic noise_due;
        logic out_free;
    } sng_status_t;

    function automatic logic signed [SUM_W-1:0] signed_level(input logic phase,
                                                             input logic [3:0] vol);
        logic signed [SUM_W-1:0] mag;
        mag = $signed(SUM_W'(VOL_LOG[vol]));
        return phase ? mag : -mag;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sng_ctrl.sv */
// ----------------------------------------------------------------------------
// sng_ctrl
// Sequencer: walks each due sample through the tone channels, the divider,
// the noise stepping and the mix, one step per cycle while out is not held.
// ----------------------------------------------------------------------------
`default_nettype none

module sng_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_operation,
    input  wire sng_pkg::sng_status_t sts,
    output sng_pkg::sng_cmd_t         cmd
);
    import sng_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_CHECK      = 3'd1;
    localparam logic [2:0] S_TONE       = 3'd2;
    localparam logic [2:0] S_DIV        = 3'd3;
    localparam logic [2:0] S_STORE      = 3'd4;
    localparam logic [2:0] S_NOISE_ADD  = 3'd5;
    localparam logic [2:0] S_NOISE_LOOP = 3'd6;
    localparam logic [2:0] S_MIX        = 3'd7;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);
    localparam logic [CH_W-1:0]   CH_LAST  = CH_W'(TONE_CHANNELS - 1);

    logic [2:0]        state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic              last_ch;

    assign last_ch  = (ch_reg == CH_LAST);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.ch       = ch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_operation == OP_WRITE)
                    begin
                        cmd.bus_write = 1'b1;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.sample_due)
                begin
                    cmd.take_sample = 1'b1;
                    ch_next         = '0;
                    state_next      = S_TONE;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TONE:
            begin
                if (sts.tone_active)
                begin
                    cmd.tone_load = 1'b1;
                    div_cnt_next  = DIV_LAST;
                    state_next    = S_DIV;
                end
                else if (last_ch)
                begin
                    state_next = S_NOISE_ADD;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            S_STORE:
            begin
                cmd.tone_store = 1'b1;
                if (last_ch)
                begin
                    state_next = S_NOISE_ADD;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_TONE;
                end
            end
            S_NOISE_ADD:
            begin
                if (sts.noise_enabled)
                begin
                    cmd.noise_add = 1'b1;
                    state_next    = S_NOISE_LOOP;
                end
                else
                begin
                    state_next = S_MIX;
                end
            end
            S_NOISE_LOOP:
            begin
                if (sts.noise_due)
                begin
                    cmd.noise_step = 1'b1;
                end
                else
                begin
                    cmd.noise_store = 1'b1;
                    state_next      = S_MIX;
                end
            end
            S_MIX:
            begin
                if (sts.out_free)
                begin
                    cmd.mix_load = 1'b1;
                    state_next   = S_CHECK;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ch_reg      <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sng_datapath.sv */
// ----------------------------------------------------------------------------
// sng_datapath
// Channel state, bus register decode, restoring divider for the tone
// counters, noise shift register, mixer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sng_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sng_pkg::in_item_t in_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [12:0]       cfg_wr_data,
    input  wire sng_pkg::sng_cmd_t cmd,
    output sng_pkg::sng_status_t   sts,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sng_pkg::out_item_t     out_data
);
    import sng_pkg::*;

    // configuration and sample timing
    logic [12:0]       cps_reg, cps_next;
    logic [13:0]       phase_reg, phase_next;
    logic [SCNT_W-1:0] cnt_reg, cnt_next;
    logic              last_reg, last_next;

    // tone channels
    logic [11:0] tone_period_reg [TONE_CHANNELS];
    logic [11:0] tone_period_next [TONE_CHANNELS];
    logic [3:0]  tone_volume_reg [TONE_CHANNELS];
    logic [3:0]  tone_volume_next [TONE_CHANNELS];
    logic [16:0] tone_count_reg [TONE_CHANNELS];
    logic [16:0] tone_count_next [TONE_CHANNELS];
    logic        tone_phase_reg [TONE_CHANNELS];
    logic        tone_phase_next [TONE_CHANNELS];
    logic        tone_enable_reg [TONE_CHANNELS];
    logic        tone_enable_next [TONE_CHANNELS];

    // noise channel
    logic [1:0]  noise_rate_reg, noise_rate_next;
    logic [3:0]  noise_volume_reg, noise_volume_next;
    logic [12:0] noise_count_reg, noise_count_next;
    logic [15:0] noise_lfsr_reg, noise_lfsr_next;
    logic        noise_phase_reg, noise_phase_next;
    logic        noise_enable_reg, noise_enable_next;

    // bus latch
    logic [2:0]  sel_reg, sel_next;
    logic        awaiting_reg, awaiting_next;

    // divider and mixer
    logic [DIV_STEPS-1:0] div_rem_reg, div_rem_next;
    logic [DIV_STEPS-1:0] div_dvd_reg, div_dvd_next;
    logic                 q_reg, q_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    // combinational helpers
    logic [11:0]           cur_period;
    logic [17:0]           tone_sum;
    logic [DIV_STEPS-1:0]  trial;
    logic                  trial_ge;
    logic                  phase_new;
    logic [12:0]           noise_period;
    logic [13:0]           noise_sum;
    logic [12:0]           cfg_sat;
    logic [13:0]           phase_left;
    logic signed [SUM_W+1:0] sum3;
    logic signed [SUM_W+1:0] scaled;
    logic signed [SUM_W+1:0] clamped;
    logic [3:0]            nib;
    logic [7:0]            wbyte;

    assign cur_period   = tone_period_reg[cmd.ch];
    assign tone_sum     = {1'b0, tone_count_reg[cmd.ch]} + 18'(cps_reg);
    assign trial        = {div_rem_reg[DIV_STEPS-2:0], div_dvd_reg[DIV_STEPS-1]};
    assign trial_ge     = (trial >= {1'b0, cur_period});
    assign phase_new    = tone_phase_reg[cmd.ch] ^ q_reg;
    assign noise_period = NOISE_BASE << noise_rate_reg;
    assign noise_sum    = {1'b0, noise_count_reg} + {1'b0, cps_reg};
    assign phase_left   = phase_reg - {1'b0, cps_reg};
    assign wbyte        = in_data.data_byte;
    assign nib          = wbyte[3:0];

    assign sum3    = $signed((SUM_W + 2)'(sum_reg)) + ($signed((SUM_W + 2)'(sum_reg)) <<< 1);
    assign scaled  = sum3 >>> 2;

    always_comb
    begin
        if (scaled > $signed((SUM_W + 2)'(MAX_AMPL)))
            clamped = $signed((SUM_W + 2)'(MAX_AMPL));
        else if (scaled < -$signed((SUM_W + 2)'(MAX_AMPL)))
            clamped = -$signed((SUM_W + 2)'(MAX_AMPL));
        else
            clamped = scaled;
    end

    always_comb
    begin
        if (cfg_wr_data < CPS_MIN)
            cfg_sat = CPS_MIN;
        else if (cfg_wr_data > CPS_MAX)
            cfg_sat = CPS_MAX;
        else
            cfg_sat = cfg_wr_data;
    end

    assign sts.sample_due    = (phase_reg >= {1'b0, cps_reg}) && (cnt_reg < SCNT_W'(MAX_SAMPLES));
    assign sts.tone_active   = tone_enable_reg[cmd.ch] && (cur_period != '0);
    assign sts.noise_enabled = noise_enable_reg;
    assign sts.noise_due     = (noise_count_reg >= noise_period);
    assign sts.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        cps_next          = cps_reg;
        phase_next        = phase_reg;
        cnt_next          = cnt_reg;
        last_next         = last_reg;
        tone_period_next  = tone_period_reg;
        tone_volume_next  = tone_volume_reg;
        tone_count_next   = tone_count_reg;
        tone_phase_next   = tone_phase_reg;
        tone_enable_next  = tone_enable_reg;
        noise_rate_next   = noise_rate_reg;
        noise_volume_next = noise_volume_reg;
        noise_count_next  = noise_count_reg;
        noise_lfsr_next   = noise_lfsr_reg;
        noise_phase_next  = noise_phase_reg;
        noise_enable_next = noise_enable_reg;
        sel_next          = sel_reg;
        awaiting_next     = awaiting_reg;
        div_rem_next      = div_rem_reg;
        div_dvd_next      = div_dvd_reg;
        q_next            = q_reg;
        sum_next          = sum_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && !out_ready;

        if (cfg_wr_en)
        begin
            cps_next = cfg_sat;
            if (phase_reg > {1'b0, cfg_sat - 1'b1})
                phase_next = {1'b0, cfg_sat - 1'b1};
        end

        // bus register write
        if (cmd.bus_write)
        begin
            if (wbyte[7])
            begin
                sel_next      = wbyte[6:4];
                awaiting_next = 1'b0;
                unique case (wbyte[6:4]) inside
                    REG_TONE0_LO, REG_TONE1_LO, REG_TONE2_LO:
                    begin
                        for (int i = 0; i < TONE_CHANNELS; i++)
                            if (2'(i) == wbyte[6:5])
                                tone_period_next[i] = {tone_period_reg[i][11:8], 4'h0, nib};
                    end
                    REG_TONE0_HI, REG_TONE1_HI, REG_TONE2_HI:
                    begin
                        for (int i = 0; i < TONE_CHANNELS; i++)
                            if (2'(i) == wbyte[6:5])
                                tone_period_next[i] = {nib, 4'h0, tone_period_reg[i][3:0]};
                    end
                    REG_NOISE:
                    begin
                        noise_rate_next = nib[1:0];
                    end
                    REG_ENABLE:
                    begin
                        for (int i = 0; i < TONE_CHANNELS && i < 3; i++)
                            tone_enable_next[i] = !nib[i];
                        noise_enable_next = !nib[3];
                    end
                endcase
            end
            else if (!awaiting_reg)
            begin
                if (sel_reg == REG_NOISE_VOL)
                begin
                    noise_volume_next = nib;
                end
                else
                begin
                    for (int i = 0; i < TONE_CHANNELS && i < 3; i++)
                        if (sel_reg == 3'(i))
                            tone_volume_next[i] = nib;
                end
            end
        end

        if (cmd.advance)
            phase_next = phase_reg + {4'h0, in_data.cycle_count};

        if (cmd.take_sample)
        begin
            phase_next = phase_left;
            cnt_next   = cnt_reg + 1'b1;
            last_next  = (phase_left < {1'b0, cps_reg})
                      || (cnt_reg == SCNT_W'(MAX_SAMPLES - 1));
            sum_next   = '0;
        end

        if (cmd.finish)
        begin
            cnt_next = '0;
            if (phase_reg > PHASE_SAT)
                phase_next = PHASE_SAT;
        end

        // tone counter: add, then divide count[16:4] by the period
        if (cmd.tone_load)
        begin
            tone_count_next[cmd.ch] = tone_sum[16:0];
            div_dvd_next            = tone_sum[16:4];
            div_rem_next            = '0;
        end

        if (cmd.div_step)
        begin
            div_dvd_next = div_dvd_reg << 1;
            q_next       = trial_ge;
            if (trial_ge)
                div_rem_next = trial - {1'b0, cur_period};
            else
                div_rem_next = trial;
        end

        // last quotient bit is the flip parity
        if (cmd.tone_store)
        begin
            tone_count_next[cmd.ch] = {1'b0, div_rem_reg[11:0], tone_count_reg[cmd.ch][3:0]};
            tone_phase_next[cmd.ch] = phase_new;
            sum_next = sum_reg + signed_level(phase_new, tone_volume_reg[cmd.ch]);
        end

        if (cmd.noise_add)
            noise_count_next = noise_sum[12:0];

        if (cmd.noise_step)
        begin
            noise_count_next = noise_count_reg - noise_period;
            noise_lfsr_next  = {noise_lfsr_reg[0] ^ noise_lfsr_reg[1], noise_lfsr_reg[15:1]};
            noise_phase_next = noise_lfsr_reg[1];
        end

        if (cmd.noise_store)
            sum_next = sum_reg + signed_level(noise_phase_reg, noise_volume_reg);

        if (cmd.mix_load)
        begin
            out_valid_next       = 1'b1;
            out_data_next.sample = 16'(clamped);
            out_data_next.last   = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg          <= CPS_RESET;
            phase_reg        <= '0;
            cnt_reg          <= '0;
            last_reg         <= 1'b0;
            for (int i = 0; i < TONE_CHANNELS; i++)
            begin
                tone_period_reg[i] <= '0;
                tone_volume_reg[i] <= '0;
                tone_count_reg[i]  <= '0;
                tone_phase_reg[i]  <= 1'b0;
                tone_enable_reg[i] <= 1'b1;
            end
            noise_rate_reg   <= '0;
            noise_volume_reg <= '0;
            noise_count_reg  <= '0;
            noise_lfsr_reg   <= LFSR_SEED;
            noise_phase_reg  <= 1'b0;
            noise_enable_reg <= 1'b1;
            sel_reg          <= '0;
            awaiting_reg     <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cps_reg          <= cps_next;
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            last_reg         <= last_next;
            tone_period_reg  <= tone_period_next;
            tone_volume_reg  <= tone_volume_next;
            tone_count_reg   <= tone_count_next;
            tone_phase_reg   <= tone_phase_next;
            tone_enable_reg  <= tone_enable_next;
            noise_rate_reg   <= noise_rate_next;
            noise_volume_reg <= noise_volume_next;
            noise_count_reg  <= noise_count_next;
            noise_lfsr_reg   <= noise_lfsr_next;
            noise_phase_reg  <= noise_phase_next;
            noise_enable_reg <= noise_enable_next;
            sel_reg          <= sel_next;
            awaiting_reg     <= awaiting_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        div_rem_reg  <= div_rem_next;
        div_dvd_reg  <= div_dvd_next;
        q_reg        <= q_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/square_noise_sound_generator.sv */
// ----------------------------------------------------------------------------
// square_noise_sound_generator
// Three square-wave tones and one noise channel, driven by bus write beats
// and time-advance beats, producing one mixed audio sample per sample period.
//
//   channel   direction   handshake           beat
//   in        input       in_valid/in_ready   write byte or cycle advance
//   out       output      out_valid/out_ready one sample, last on final one
//   cfg       input       cfg_wr_en           cycles per sample, no stall
//
// a write beat is applied while the sequencer idles; an advance beat walks
// each due sample through every sounding tone (13-step divider), past each
// silent tone, then through the noise shifts and the mix, with in_ready low
// until it is done. reset is asynchronous and leaves no clearing pass.
// a held sample on out stalls the sequencer only when the next one is mixed.
// ----------------------------------------------------------------------------
`default_nettype none

module square_noise_sound_generator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sng_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sng_pkg::out_item_t     out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [12:0]       cfg_wr_data
);
    import sng_pkg::*;

    sng_cmd_t    cmd;
    sng_status_t sts;

    sng_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_operation (in_data.operation),
        .sts          (sts),
        .cmd          (cmd)
    );

    sng_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
